### rtl/core/c8b10b_pkg.sv
// Shared types, code tables and helpers for the 8b/10b data codec.
// No dependencies; used by every module of the codec.

package c8b10b_pkg;

  typedef enum logic [0:0] {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [7:0]  data_byte;
    logic [9:0]  code_in;
  } item_t;

  typedef struct packed {
    logic [9:0]  code_out;
    logic [7:0]  data_out;
    logic        decode_error;
    logic        disparity_positive;
  } result_t;

  localparam int SIX_COUNT  = 32;
  localparam int FOUR_COUNT = 8;

  // 5b/6b codes, index EDCBA, for negative and positive running disparity
  localparam logic [5:0] SIX_NEG [SIX_COUNT] = '{
    6'h27, 6'h1D, 6'h2D, 6'h31, 6'h35, 6'h29, 6'h19, 6'h38,
    6'h39, 6'h25, 6'h15, 6'h34, 6'h0D, 6'h2C, 6'h1C, 6'h17,
    6'h1B, 6'h23, 6'h13, 6'h32, 6'h0B, 6'h2A, 6'h1A, 6'h3A,
    6'h33, 6'h26, 6'h16, 6'h36, 6'h0E, 6'h2E, 6'h1E, 6'h2B
  };

  localparam logic [5:0] SIX_POS [SIX_COUNT] = '{
    6'h18, 6'h22, 6'h12, 6'h31, 6'h0A, 6'h29, 6'h19, 6'h07,
    6'h06, 6'h25, 6'h15, 6'h34, 6'h0D, 6'h2C, 6'h1C, 6'h28,
    6'h24, 6'h23, 6'h13, 6'h32, 6'h0B, 6'h2A, 6'h1A, 6'h05,
    6'h0C, 6'h26, 6'h16, 6'h09, 6'h0E, 6'h11, 6'h21, 6'h14
  };

  // 3b/4b codes, index HGF
  localparam logic [3:0] FOUR_NEG [FOUR_COUNT] = '{
    4'hB, 4'h9, 4'h5, 4'hC, 4'hD, 4'hA, 4'h6, 4'hE
  };

  localparam logic [3:0] FOUR_POS [FOUR_COUNT] = '{
    4'h4, 4'h9, 4'h5, 4'h3, 4'h2, 4'hA, 4'h6, 4'h1
  };

  // True when a six-bit subblock does not hold three ones
  function automatic logic unbalanced6(input logic [5:0] code);
    logic [2:0] ones;
    ones = 3'd0;
    for (int i = 0; i < 6; i++) begin
      ones = ones + {2'b00, code[i]};
    end
    return ones != 3'd3;
  endfunction

  // True when a four-bit subblock does not hold two ones
  function automatic logic unbalanced4(input logic [3:0] code);
    logic [2:0] ones;
    ones = 3'd0;
    for (int i = 0; i < 4; i++) begin
      ones = ones + {2'b00, code[i]};
    end
    return ones != 3'd2;
  endfunction

endpackage

### rtl/core/c8b10b_enc.sv
// Combinational 8b/10b data encoder with running disparity update.
// Depends on c8b10b_pkg for the code tables and balance helpers.

module c8b10b_enc
  import c8b10b_pkg::*;
(
  input  logic [7:0] data_byte,
  input  logic       rd,
  output logic [9:0] code,
  output logic       rd_after
);

  logic [5:0] c6;
  logic [3:0] c4;
  logic       rd_mid;

  always_comb begin
    c6       = rd ? SIX_POS[data_byte[4:0]] : SIX_NEG[data_byte[4:0]];
    rd_mid   = rd ^ unbalanced6(c6);
    c4       = rd_mid ? FOUR_POS[data_byte[7:5]] : FOUR_NEG[data_byte[7:5]];
    rd_after = rd_mid ^ unbalanced4(c4);
    code     = {c6, c4};
  end

endmodule

### rtl/core/c8b10b_dec.sv
// Combinational 8b/10b data decoder; accepts codes of either disparity.
// Depends on c8b10b_pkg for the code tables.

module c8b10b_dec
  import c8b10b_pkg::*;
(
  input  logic [9:0] code,
  output logic [7:0] data,
  output logic       error
);

  logic [4:0] lo_idx;
  logic [2:0] hi_idx;
  logic       lo_hit;
  logic       hi_hit;

  // lowest matching index wins
  always_comb begin
    lo_idx = '0;
    lo_hit = 1'b0;
    for (int i = SIX_COUNT - 1; i >= 0; i--) begin
      if (SIX_NEG[i] == code[9:4] || SIX_POS[i] == code[9:4]) begin
        lo_idx = 5'(i);
        lo_hit = 1'b1;
      end
    end
    hi_idx = '0;
    hi_hit = 1'b0;
    for (int j = FOUR_COUNT - 1; j >= 0; j--) begin
      if (FOUR_NEG[j] == code[3:0] || FOUR_POS[j] == code[3:0]) begin
        hi_idx = 3'(j);
        hi_hit = 1'b1;
      end
    end
    error = !(lo_hit && hi_hit);
    data  = error ? 8'h00 : {hi_idx, lo_idx};
  end

endmodule

### rtl/core/codec_8b10b_with_disparity.sv
// 8b/10b data codec top level: input register, encode/decode, result register.
// Depends on c8b10b_pkg, c8b10b_enc and c8b10b_dec.
// The item passes the input register, then the result register, before result_valid.
// Throughput: one item per cycle while result_ready is high; the disparity register updates as each item advances.
// Reset (rst, synchronous): both stages empty, running disparity positive.

module codec_8b10b_with_disparity
  import c8b10b_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic    s1_valid;
  item_t   s1;
  logic    rd;
  logic    res_valid;
  result_t res;

  logic    adv;
  logic [9:0] enc_code;
  logic       rd_next;
  logic [7:0] dec_data;
  logic       dec_error;
  result_t    res_next;
  logic       rd_enc;

  c8b10b_enc u_enc (
    .data_byte (s1.data_byte),
    .rd        (rd),
    .code      (enc_code),
    .rd_after  (rd_enc)
  );

  c8b10b_dec u_dec (
    .code  (s1.code_in),
    .data  (dec_data),
    .error (dec_error)
  );

  assign adv        = !res_valid || result_ready;
  assign item_ready = !s1_valid || adv;

  always_comb begin
    if (s1.opcode == OP_DECODE) begin
      rd_next                     = rd;
      res_next.code_out           = 10'd0;
      res_next.data_out           = dec_data;
      res_next.decode_error       = dec_error;
    end else begin
      rd_next                     = rd_enc;
      res_next.code_out           = enc_code;
      res_next.data_out           = 8'd0;
      res_next.decode_error       = 1'b0;
    end
    res_next.disparity_positive = rd_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
      rd        <= 1'b1;
    end else begin
      if (item_ready) begin
        s1_valid <= item_valid;
      end
      if (adv) begin
        res_valid <= s1_valid;
      end
      if (adv && s1_valid) begin
        rd <= rd_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1 <= item;
    end
    if (adv && s1_valid) begin
      res <= res_next;
    end
  end

  assign result_valid = res_valid;
  assign result       = res;

endmodule

### rtl/core/c8b10b_chk.sv
// Port-level checker for the 8b/10b codec, bound to the top level.
// Depends on c8b10b_pkg for the result beat type.

module c8b10b_chk
  import c8b10b_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result beat dropped or changed");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.decode_error |->
      result.data_out == 8'd0 && result.code_out == 10'd0)
    else $error("error beat carries data");

  a_encode_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.code_out != 10'd0 |->
      result.data_out == 8'd0 && !result.decode_error)
    else $error("encode beat carries decode fields");

  a_encode_balance: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.code_out != 10'd0 |->
      $countones(result.code_out) == 4 || $countones(result.code_out) == 5 ||
      $countones(result.code_out) == 6)
    else $error("encoded word out of disparity bounds");

endmodule

bind codec_8b10b_with_disparity c8b10b_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

### tb/codec_8b10b_with_disparity_tb.sv
// Self-checking testbench for the 8b/10b data codec with running disparity.
// Uses c8b10b_pkg types; drives a directed vector table, then random beats with
// random idling and a long receiver hold-off, checked against a local predictor.

module codec_8b10b_with_disparity_tb;
  import c8b10b_pkg::*;

  localparam int QUIET_LIMIT  = 500;
  localparam int HOLD_CYCLES  = 64;
  localparam int RANDOM_ITEMS = 400;
  localparam int N_DIRECTED   = 22;

  typedef struct packed {
    item_t   stim;
    logic    known;
    result_t want;
  } vector_t;

  localparam logic [5:0] CODE6_NEG [32] = '{
    6'h27, 6'h1D, 6'h2D, 6'h31, 6'h35, 6'h29, 6'h19, 6'h38,
    6'h39, 6'h25, 6'h15, 6'h34, 6'h0D, 6'h2C, 6'h1C, 6'h17,
    6'h1B, 6'h23, 6'h13, 6'h32, 6'h0B, 6'h2A, 6'h1A, 6'h3A,
    6'h33, 6'h26, 6'h16, 6'h36, 6'h0E, 6'h2E, 6'h1E, 6'h2B
  };
  localparam logic [5:0] CODE6_POS [32] = '{
    6'h18, 6'h22, 6'h12, 6'h31, 6'h0A, 6'h29, 6'h19, 6'h07,
    6'h06, 6'h25, 6'h15, 6'h34, 6'h0D, 6'h2C, 6'h1C, 6'h28,
    6'h24, 6'h23, 6'h13, 6'h32, 6'h0B, 6'h2A, 6'h1A, 6'h05,
    6'h0C, 6'h26, 6'h16, 6'h09, 6'h0E, 6'h11, 6'h21, 6'h14
  };
  localparam logic [3:0] CODE4_NEG [8] = '{
    4'hB, 4'h9, 4'h5, 4'hC, 4'hD, 4'hA, 4'h6, 4'hE
  };
  localparam logic [3:0] CODE4_POS [8] = '{
    4'h4, 4'h9, 4'h5, 4'h3, 4'h2, 4'hA, 4'h6, 4'h1
  };

  // Rows run straight after reset, so the typed-in expectations assume RD+ there
  localparam vector_t DIRECTED [N_DIRECTED] = '{
    '{'{OP_ENCODE, 8'h00, 10'h3FF}, 1'b1, '{10'h18B, 8'h00, 1'b0, 1'b1}},
    '{'{OP_ENCODE, 8'hFF, 10'h000}, 1'b1, '{10'h14E, 8'h00, 1'b0, 1'b1}},
    '{'{OP_DECODE, 8'hFF, 10'h18B}, 1'b1, '{10'h000, 8'h00, 1'b0, 1'b1}},
    '{'{OP_DECODE, 8'h00, 10'h14E}, 1'b1, '{10'h000, 8'hFF, 1'b0, 1'b1}},
    '{'{OP_DECODE, 8'hA5, 10'h3FF}, 1'b1, '{10'h000, 8'h00, 1'b1, 1'b1}},
    '{'{OP_DECODE, 8'h5A, 10'h000}, 1'b1, '{10'h000, 8'h00, 1'b1, 1'b1}},
    '{'{OP_DECODE, 8'h00, 10'h18F}, 1'b1, '{10'h000, 8'h00, 1'b1, 1'b1}},
    '{'{OP_DECODE, 8'h00, 10'h3F9}, 1'b1, '{10'h000, 8'h00, 1'b1, 1'b1}},
    '{'{OP_ENCODE, 8'h03, 10'h155}, 1'b0, '0},
    '{'{OP_DECODE, 8'h00, 10'h314}, 1'b0, '0},
    '{'{OP_ENCODE, 8'h23, 10'h2AA}, 1'b0, '0},
    '{'{OP_ENCODE, 8'h07, 10'h000}, 1'b0, '0},
    '{'{OP_DECODE, 8'h00, 10'h274}, 1'b0, '0},
    '{'{OP_DECODE, 8'h00, 10'h1D9}, 1'b0, '0},
    '{'{OP_DECODE, 8'h00, 10'h071}, 1'b0, '0},
    '{'{OP_ENCODE, 8'h1F, 10'h3FF}, 1'b0, '0},
    '{'{OP_ENCODE, 8'hE0, 10'h000}, 1'b0, '0},
    '{'{OP_ENCODE, 8'h80, 10'h200}, 1'b0, '0},
    '{'{OP_ENCODE, 8'h55, 10'h155}, 1'b0, '0},
    '{'{OP_ENCODE, 8'hAA, 10'h2AA}, 1'b0, '0},
    '{'{OP_ENCODE, 8'h1C, 10'h000}, 1'b0, '0},
    '{'{OP_DECODE, 8'h00, 10'h3FC}, 1'b0, '0}
  };

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  logic    rd_positive = 1'b1;
  logic    steady = 1'b0;
  logic    hold_request = 1'b0;
  int      mismatches = 0;
  int      quiet_cycles = 0;
  int      results_seen = 0;
  result_t expected_results [$];

  codec_8b10b_with_disparity dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #1 clk = ~clk;

  function automatic result_t predict_character(input item_t stim);
    result_t    r;
    logic [5:0] c6;
    logic [3:0] c4;
    int         lo;
    int         hi;
    r  = '0;
    lo = -1;
    hi = -1;
    if (stim.opcode == OP_ENCODE) begin
      c6 = rd_positive ? CODE6_POS[stim.data_byte[4:0]] : CODE6_NEG[stim.data_byte[4:0]];
      if ($countones(c6) != 3) rd_positive = ~rd_positive;
      c4 = rd_positive ? CODE4_POS[stim.data_byte[7:5]] : CODE4_NEG[stim.data_byte[7:5]];
      if ($countones(c4) != 2) rd_positive = ~rd_positive;
      r.code_out = {c6, c4};
    end else begin
      for (int i = 31; i >= 0; i--) begin
        if (CODE6_NEG[i] == stim.code_in[9:4] || CODE6_POS[i] == stim.code_in[9:4]) lo = i;
      end
      for (int i = 7; i >= 0; i--) begin
        if (CODE4_NEG[i] == stim.code_in[3:0] || CODE4_POS[i] == stim.code_in[3:0]) hi = i;
      end
      if (lo < 0 || hi < 0) begin
        r.decode_error = 1'b1;
      end else begin
        r.data_out = {hi[2:0], lo[4:0]};
      end
    end
    r.disparity_positive = rd_positive;
    return r;
  endfunction

  function automatic void report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH beat %0d: %s", results_seen, msg);
  endfunction

  function automatic void check_result(input result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result %h", got));
      return;
    end
    want = expected_results.pop_front();
    if (got.code_out !== want.code_out)
      report_mismatch($sformatf("code_out exp %h got %h", want.code_out, got.code_out));
    if (got.data_out !== want.data_out)
      report_mismatch($sformatf("data_out exp %h got %h", want.data_out, got.data_out));
    if (got.decode_error !== want.decode_error)
      report_mismatch($sformatf("decode_error exp %b got %b",
                                want.decode_error, got.decode_error));
    if (got.disparity_positive !== want.disparity_positive)
      report_mismatch($sformatf("disparity_positive exp %b got %b",
                                want.disparity_positive, got.disparity_positive));
  endfunction

  task automatic offer_item(input item_t stim, input logic known, input result_t want);
    int      gap;
    logic    took;
    result_t predicted;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= stim;
    do begin
      @(negedge clk);
      took = item_ready;
      @(posedge clk);
    end while (!took);
    predicted = predict_character(stim);
    expected_results.push_back(known ? want : predicted);
  endtask

  initial begin
    int    pick;
    item_t stim;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (int k = 0; k < N_DIRECTED; k++) begin
      offer_item(DIRECTED[k].stim, DIRECTED[k].known, DIRECTED[k].want);
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 120 && n < 180) || (n >= 250 && n < 300);
      if (n == 250) hold_request = 1'b1;
      pick           = $urandom_range(0, 9);
      stim.opcode    = (pick < 5) ? OP_ENCODE : OP_DECODE;
      stim.data_byte = 8'($urandom_range(0, 255));
      stim.code_in   = 10'($urandom_range(0, 1023));
      // mostly well-formed code words, from either disparity's table
      if (pick >= 5 && pick <= 8) begin
        stim.code_in[9:4] = $urandom_range(0, 1) ? CODE6_POS[5'($urandom_range(0, 31))]
                                                 : CODE6_NEG[5'($urandom_range(0, 31))];
        if (pick != 8) begin
          stim.code_in[3:0] = $urandom_range(0, 1) ? CODE4_POS[3'($urandom_range(0, 7))]
                                                   : CODE4_NEG[3'($urandom_range(0, 7))];
        end
      end
      offer_item(stim, 1'b0, '0);
    end
    steady = 1'b0;
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    int      stall;
    logic    got;
    result_t seen;
    wait (rst == 1'b0);
    forever begin
      if (hold_request) begin
        stall = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        stall = steady ? 0 : $urandom_range(0, 7);
      end
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do begin
        @(negedge clk);
        got  = result_valid;
        seen = result;
        @(posedge clk);
      end while (!got);
      results_seen++;
      check_result(seen);
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(negedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("TIMEOUT: no beat for %0d cycles", QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

endmodule
